// ----- hdl/obb_pkg.sv -----
// Shared widths, types and axis pairing tables for the 2D OBB overlap test.
`default_nettype none

package obb_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned NumEdges = 4;
  localparam int unsigned NumPairs = NumEdges * (NumEdges + 1) / 2;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned DotW     = ProdW + 1;
  localparam int unsigned MagW     = ProdW;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned GapProdW = DiffW + CoordW;
  localparam int unsigned GapDotW  = GapProdW + 1;
  localparam int unsigned GapMagW  = GapDotW - 1;
  localparam int unsigned ExtW     = MagW + 2;

  typedef logic signed [CoordW-1:0]   coord_t;
  typedef logic signed [DiffW-1:0]    diff_t;
  typedef logic signed [ProdW-1:0]    prod_t;
  typedef logic signed [DotW-1:0]     dot_t;
  typedef logic        [MagW-1:0]     mag_t;
  typedef logic signed [GapProdW-1:0] gap_prod_t;
  typedef logic signed [GapDotW-1:0]  gap_dot_t;
  typedef logic        [GapMagW-1:0]  gap_mag_t;
  typedef logic        [ExtW-1:0]     ext_t;
  typedef logic        [3:0]          pair_idx_t;
  typedef logic        [1:0]          edge_idx_t;

  // Edge order: A.u, A.v, B.u, B.v. Each unordered edge pair is computed once.
  localparam edge_idx_t PairA [NumPairs] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
                                             2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
  localparam edge_idx_t PairB [NumPairs] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                             2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  localparam pair_idx_t AxisPair [NumEdges][NumEdges] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3},
    '{4'd1, 4'd4, 4'd5, 4'd6},
    '{4'd2, 4'd5, 4'd7, 4'd8},
    '{4'd3, 4'd6, 4'd8, 4'd9}
  };

endpackage

`default_nettype wire

// ----- hdl/obb_overlap_test_2d_core.sv -----
// Throughput: one box pair per cycle while no held result is stalled, with a four-deep pipeline
// (input register, product register, dot/abs register, result register).
// The whole pipeline freezes while a held result is stalled.
// Reset (rst_ni, async active low) clears only the stage valid bits.
`default_nettype none

module obb_overlap_test_2d_core
  import obb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire coord_t       box_a_u_x_i,
  input  wire coord_t       box_a_u_y_i,
  input  wire coord_t       box_a_v_x_i,
  input  wire coord_t       box_a_v_y_i,
  input  wire coord_t       box_a_center_x_i,
  input  wire coord_t       box_a_center_y_i,
  input  wire coord_t       box_b_u_x_i,
  input  wire coord_t       box_b_u_y_i,
  input  wire coord_t       box_b_v_x_i,
  input  wire coord_t       box_b_v_y_i,
  input  wire coord_t       box_b_center_x_i,
  input  wire coord_t       box_b_center_y_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic              overlapping_o
);

  logic en;

  logic   s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  coord_t edge_x_q [NumEdges];
  coord_t edge_y_q [NumEdges];
  diff_t  dx_q, dy_q;

  prod_t     pp_x_q [NumPairs];
  prod_t     pp_y_q [NumPairs];
  gap_prod_t gp_x_q [NumEdges];
  gap_prod_t gp_y_q [NumEdges];

  mag_t     mag_d [NumPairs];
  mag_t     mag_q [NumPairs];
  gap_mag_t gap_d [NumEdges];
  gap_mag_t gap_q [NumEdges];

  logic overlap_d, overlap_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: capture edges and center difference
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      edge_x_q[0] <= box_a_u_x_i;
      edge_y_q[0] <= box_a_u_y_i;
      edge_x_q[1] <= box_a_v_x_i;
      edge_y_q[1] <= box_a_v_y_i;
      edge_x_q[2] <= box_b_u_x_i;
      edge_y_q[2] <= box_b_u_y_i;
      edge_x_q[3] <= box_b_v_x_i;
      edge_y_q[3] <= box_b_v_y_i;
      dx_q        <= DiffW'(box_a_center_x_i) - DiffW'(box_b_center_x_i);
      dy_q        <= DiffW'(box_a_center_y_i) - DiffW'(box_b_center_y_i);
    end
  end

  // Stage 2: all products, one multiplier per lane
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NumPairs; k++) begin
        pp_x_q[k] <= ProdW'(edge_x_q[PairA[k]]) * ProdW'(edge_x_q[PairB[k]]);
        pp_y_q[k] <= ProdW'(edge_y_q[PairA[k]]) * ProdW'(edge_y_q[PairB[k]]);
      end
      for (int i = 0; i < NumEdges; i++) begin
        gp_x_q[i] <= GapProdW'(dx_q) * GapProdW'(edge_x_q[i]);
        gp_y_q[i] <= GapProdW'(dy_q) * GapProdW'(edge_y_q[i]);
      end
    end
  end

  // Stage 3: dot products and magnitudes
  always_comb begin
    dot_t     dot;
    gap_dot_t gdot;
    for (int k = 0; k < NumPairs; k++) begin
      dot      = DotW'(pp_x_q[k]) + DotW'(pp_y_q[k]);
      mag_d[k] = dot[DotW-1] ? MagW'(-dot) : MagW'(dot);
    end
    for (int i = 0; i < NumEdges; i++) begin
      gdot     = GapDotW'(gp_x_q[i]) + GapDotW'(gp_y_q[i]);
      gap_d[i] = gdot[GapDotW-1] ? GapMagW'(-gdot) : GapMagW'(gdot);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= mag_d;
      gap_q <= gap_d;
    end
  end

  // Stage 4: extent sum per axis against twice the projected distance
  always_comb begin
    ext_t ext;
    ext_t gap2;
    overlap_d = 1'b1;
    for (int i = 0; i < NumEdges; i++) begin
      ext = '0;
      for (int j = 0; j < NumEdges; j++) begin
        ext = ext + ExtW'(mag_q[AxisPair[i][j]]);
      end
      gap2 = {gap_q[i], 1'b0};
      if (ext < gap2) begin
        overlap_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s3_valid_q) begin
      overlap_q <= overlap_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign overlapping_o = overlap_q;

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s3_valid_q) |=> out_valid_o)
    else $error("valid stage 3 transaction did not reach the result register");

  a_bubble_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !s3_valid_q) |=> !out_valid_o)
    else $error("result presented without a transaction behind it");

  a_accept_reaches_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted transaction lost at stage 1");

endmodule

`default_nettype wire

// ----- sim/obb_overlap_test_2d_core_test.sv -----
// Self-checking testbench for the 2D OBB overlap core: directed table, then random box pairs.
`timescale 1ns / 1ps

module obb_overlap_test_2d_core_test;
  import obb_pkg::*;

  typedef struct packed {
    coord_t box_a_u_x;
    coord_t box_a_u_y;
    coord_t box_a_v_x;
    coord_t box_a_v_y;
    coord_t box_a_center_x;
    coord_t box_a_center_y;
    coord_t box_b_u_x;
    coord_t box_b_u_y;
    coord_t box_b_v_x;
    coord_t box_b_v_y;
    coord_t box_b_center_x;
    coord_t box_b_center_y;
  } box_pair_t;

  typedef enum logic [1:0] {
    VERDICT_PREDICT,
    VERDICT_OVERLAP,
    VERDICT_APART
  } verdict_src_e;

  typedef struct {
    box_pair_t    pair;
    verdict_src_e src;
  } stim_row_t;

  localparam coord_t U    = 32'sd65536;
  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;
  localparam int unsigned IDLE_PCT = 17;
  localparam int unsigned NUM_RANDOM = 1550;

  logic   clk_i;
  logic   rst_ni           = 1'b0;
  logic   in_valid_i       = 1'b0;
  logic   in_stall_o;
  coord_t box_a_u_x_i      = '0;
  coord_t box_a_u_y_i      = '0;
  coord_t box_a_v_x_i      = '0;
  coord_t box_a_v_y_i      = '0;
  coord_t box_a_center_x_i = '0;
  coord_t box_a_center_y_i = '0;
  coord_t box_b_u_x_i      = '0;
  coord_t box_b_u_y_i      = '0;
  coord_t box_b_v_x_i      = '0;
  coord_t box_b_v_y_i      = '0;
  coord_t box_b_center_x_i = '0;
  coord_t box_b_center_y_i = '0;
  logic   out_valid_o;
  logic   out_stall_i      = 1'b0;
  logic   overlapping_o;

  logic      verdict_q [$];
  stim_row_t directed_rows [$];
  logic      quiet = 1'b0;
  logic      want_overlap;
  int        mismatch_count = 0;

  obb_overlap_test_2d_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .box_a_u_x_i      (box_a_u_x_i),
    .box_a_u_y_i      (box_a_u_y_i),
    .box_a_v_x_i      (box_a_v_x_i),
    .box_a_v_y_i      (box_a_v_y_i),
    .box_a_center_x_i (box_a_center_x_i),
    .box_a_center_y_i (box_a_center_y_i),
    .box_b_u_x_i      (box_b_u_x_i),
    .box_b_u_y_i      (box_b_u_y_i),
    .box_b_v_x_i      (box_b_v_x_i),
    .box_b_v_y_i      (box_b_v_y_i),
    .box_b_center_x_i (box_b_center_x_i),
    .box_b_center_y_i (box_b_center_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .overlapping_o    (overlapping_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("obb_overlap_test_2d_core_test: done, errors");
    $finish;
  end

  // Exact separating-axis test, both sides scaled by 2|p|.
  function automatic logic predict_overlap(box_pair_t p);
    logic signed [127:0] ex [4];
    logic signed [127:0] ey [4];
    logic signed [127:0] dx, dy, t, extent, gap;
    logic hit;
    ex[0] = p.box_a_u_x;  ey[0] = p.box_a_u_y;
    ex[1] = p.box_a_v_x;  ey[1] = p.box_a_v_y;
    ex[2] = p.box_b_u_x;  ey[2] = p.box_b_u_y;
    ex[3] = p.box_b_v_x;  ey[3] = p.box_b_v_y;
    dx = p.box_a_center_x;
    dx = dx - p.box_b_center_x;
    dy = p.box_a_center_y;
    dy = dy - p.box_b_center_y;
    hit = 1'b1;
    for (int i = 0; i < 4; i++) begin
      extent = '0;
      for (int j = 0; j < 4; j++) begin
        t = ex[i] * ex[j] + ey[i] * ey[j];
        extent = extent + ((t < 0) ? -t : t);
      end
      t = dx * ex[i] + dy * ey[i];
      gap = ((t < 0) ? -t : t) * 2;
      if (extent < gap) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic void add_row(coord_t aux, coord_t auy, coord_t avx, coord_t avy,
                                  coord_t acx, coord_t acy, coord_t bux, coord_t buy,
                                  coord_t bvx, coord_t bvy, coord_t bcx, coord_t bcy,
                                  verdict_src_e src);
    stim_row_t r;
    r.pair = '{aux, auy, avx, avy, acx, acy, bux, buy, bvx, bvy, bcx, bcy};
    r.src  = src;
    directed_rows.push_back(r);
  endfunction

  function automatic coord_t rand_shifted(int unsigned sh);
    return coord_t'($urandom) >>> sh;
  endfunction

  function automatic box_pair_t rand_pair();
    box_pair_t   p;
    int          wa, ha, wb, hb, sep, lat;
    coord_t      a, b, c, d;
    int unsigned pick;
    pick = $urandom_range(99);
    p = '0;
    if (pick < 25) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (pick < 50 || pick >= 90) begin
      p.box_a_u_x = rand_shifted(11);  p.box_a_u_y = rand_shifted(11);
      p.box_a_v_x = rand_shifted(11);  p.box_a_v_y = rand_shifted(11);
      p.box_b_u_x = rand_shifted(11);  p.box_b_u_y = rand_shifted(11);
      p.box_b_v_x = rand_shifted(11);  p.box_b_v_y = rand_shifted(11);
      p.box_a_center_x = rand_shifted(10);  p.box_a_center_y = rand_shifted(10);
      p.box_b_center_x = rand_shifted(10);  p.box_b_center_y = rand_shifted(10);
      if (pick >= 90) begin
        // degenerate: zero or parallel edges
        case ($urandom_range(3))
          0: begin
            p.box_a_v_x = '0;  p.box_a_v_y = '0;
          end
          1: begin
            p.box_a_v_x = -p.box_a_u_x;  p.box_a_v_y = -p.box_a_u_y;
          end
          2: begin
            p.box_b_u_x = p.box_a_u_x;  p.box_b_u_y = p.box_a_u_y;
            p.box_b_v_x = '0;           p.box_b_v_y = '0;
          end
          default: begin
            p.box_b_u_x = '0;  p.box_b_u_y = '0;
            p.box_b_v_x = '0;  p.box_b_v_y = '0;
          end
        endcase
      end
    end else if (pick < 75) begin
      // axis-aligned boxes placed within a few LSBs of touching
      wa = 2 * int'($urandom_range(1, 1 << 17));
      ha = 2 * int'($urandom_range(1, 1 << 17));
      wb = 2 * int'($urandom_range(1, 1 << 17));
      hb = 2 * int'($urandom_range(1, 1 << 17));
      sep = (wa + wb) / 2 + int'($urandom_range(4)) - 2;
      lat = int'($urandom_range((ha + hb) / 2)) - (ha + hb) / 4;
      if ($urandom_range(1)) sep = -sep;
      p.box_a_center_x = rand_shifted(4);
      p.box_a_center_y = rand_shifted(4);
      if ($urandom_range(1)) begin
        p.box_a_u_y = wa;  p.box_a_v_x = ha;
        p.box_b_u_y = wb;  p.box_b_v_x = hb;
        p.box_b_center_x = p.box_a_center_x + lat;
        p.box_b_center_y = p.box_a_center_y + sep;
      end else begin
        p.box_a_u_x = wa;  p.box_a_v_y = ha;
        p.box_b_u_x = wb;  p.box_b_v_y = hb;
        p.box_b_center_x = p.box_a_center_x + sep;
        p.box_b_center_y = p.box_a_center_y + lat;
      end
      if ($urandom_range(1)) begin
        p.box_a_u_x = -p.box_a_u_x;  p.box_a_u_y = -p.box_a_u_y;
      end
      if ($urandom_range(1)) begin
        p.box_b_v_x = -p.box_b_v_x;  p.box_b_v_y = -p.box_b_v_y;
      end
    end else begin
      // rotated rectangles with orthogonal edges
      a = rand_shifted(17);  b = rand_shifted(17);
      c = rand_shifted(17);  d = rand_shifted(17);
      p.box_a_u_x = a;   p.box_a_u_y = b;
      p.box_a_v_x = -b;  p.box_a_v_y = a;
      p.box_b_u_x = c;   p.box_b_u_y = d;
      p.box_b_v_x = -d;  p.box_b_v_y = c;
      p.box_a_center_x = rand_shifted(15);  p.box_a_center_y = rand_shifted(15);
      p.box_b_center_x = rand_shifted(15);  p.box_b_center_y = rand_shifted(15);
    end
    return p;
  endfunction

  task automatic send_pair(box_pair_t p, logic verdict);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    box_a_u_x_i      <= p.box_a_u_x;
    box_a_u_y_i      <= p.box_a_u_y;
    box_a_v_x_i      <= p.box_a_v_x;
    box_a_v_y_i      <= p.box_a_v_y;
    box_a_center_x_i <= p.box_a_center_x;
    box_a_center_y_i <= p.box_a_center_y;
    box_b_u_x_i      <= p.box_b_u_x;
    box_b_u_y_i      <= p.box_b_u_y;
    box_b_v_x_i      <= p.box_b_v_x;
    box_b_v_y_i      <= p.box_b_v_y;
    box_b_center_x_i <= p.box_b_center_x;
    box_b_center_y_i <= p.box_b_center_y;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    verdict_q.push_back(verdict);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // result side: check each transaction, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual overlapping=%0b",
                 $time, overlapping_o);
        mismatch_count++;
      end else begin
        want_overlap = verdict_q.pop_front();
        if (overlapping_o !== want_overlap) begin
          $display("%0t: overlapping mismatch, expected %0b, actual %0b",
                   $time, want_overlap, overlapping_o);
          mismatch_count++;
        end
      end
    end
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  initial begin
    // unit boxes and degenerate cases
    add_row('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, VERDICT_OVERLAP);
    add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
            VERDICT_OVERLAP);
    add_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
            VERDICT_OVERLAP);
    add_row(U, '0, '0, U, '0, '0, U, '0, '0, U, '0, '0, VERDICT_OVERLAP);
    add_row(U, '0, '0, U, '0, '0, U, '0, '0, U, 3 * U, '0, VERDICT_APART);
    // touching counts as overlap; one LSB further separates
    add_row(U, '0, '0, U, '0, '0, U, '0, '0, U, U, '0, VERDICT_OVERLAP);
    add_row(U, '0, '0, U, '0, '0, U, '0, '0, U, U + 1, '0, VERDICT_APART);
    add_row(U, '0, '0, U, '0, '0, U, '0, '0, U, '0, -U, VERDICT_OVERLAP);
    add_row(U, '0, '0, U, '0, '0, U, '0, '0, U, '0, -U - 1, VERDICT_APART);
    // zero-length axes never separate
    add_row('0, '0, '0, '0, CMAX, CMAX, '0, '0, '0, '0, CMIN, CMIN, VERDICT_OVERLAP);
    add_row(U, '0, '0, '0, '0, '0, 2 * U, '0, '0, '0, '0, 5 * U, VERDICT_OVERLAP);
    add_row(U, '0, '0, U, CMAX, CMAX, U, '0, '0, U, CMIN, CMIN, VERDICT_APART);
    add_row(-U, '0, '0, -U, '0, '0, U, '0, '0, U, -3 * U, '0, VERDICT_APART);
    // full-scale operands and rotated boxes
    add_row(CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX,
            VERDICT_PREDICT);
    add_row(CMAX, CMIN, CMIN, CMIN, CMAX, '0, CMIN, CMAX, CMAX, CMAX, CMIN, '0,
            VERDICT_PREDICT);
    add_row(CMAX, '0, '0, CMAX, '0, '0, U, '0, '0, U, CMAX, CMAX, VERDICT_PREDICT);
    add_row(U, U, -U, U, '0, '0, U, '0, '0, U, 2 * U, '0, VERDICT_PREDICT);
    add_row(U, U, -U, U, '0, '0, U, '0, '0, U, 3 * U / 2, U / 4, VERDICT_PREDICT);
    add_row(U, '0, '0, U, '0, '0, U / 4, U / 4, -U / 4, U / 4, 32'sd45875, 32'sd45875,
            VERDICT_PREDICT);
    add_row(32'sh12345678, 32'shedcba987, 32'sh00abcdef, 32'sh7f00ff00, 32'sh80000001,
            32'sh0badf00d, 32'shfffffffe, 32'sh00000001, 32'sh55555555, 32'shaaaaaaaa,
            32'sh7ffffffe, 32'sh80000002, VERDICT_PREDICT);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      case (directed_rows[k].src)
        VERDICT_OVERLAP: send_pair(directed_rows[k].pair, 1'b1);
        VERDICT_APART:   send_pair(directed_rows[k].pair, 1'b0);
        default:         send_pair(directed_rows[k].pair,
                                   predict_overlap(directed_rows[k].pair));
      endcase
    end
    wait_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      box_pair_t p;
      if (n == 400) wait_drained();
      quiet = (n >= 700 && n < 1000);
      p = rand_pair();
      send_pair(p, predict_overlap(p));
    end
    quiet = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("obb_overlap_test_2d_core_test: done, clean");
    end else begin
      $display("obb_overlap_test_2d_core_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/obb_pkg.sv
hdl/obb_overlap_test_2d_core.sv
sim/obb_overlap_test_2d_core_test.sv
